@@ rtl/bucket_table_dedup_insert_unit_assert.svh @@
// Assertion macros for the bucket table insert unit.
// Uses clk and rst_n from the including module's scope.
`ifndef BUCKET_TABLE_DEDUP_INSERT_UNIT_ASSERT_SVH
`define BUCKET_TABLE_DEDUP_INSERT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BKDI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bkdi: implication check failed");
`define BKDI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bkdi: next-cycle check failed");
`else
`define BKDI_ASSERT_IMP(lbl, ante, cons)
`define BKDI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/bkdi_pkg.sv @@
// Shared types and constants for the bucket table insert unit.
// No dependencies.
`default_nettype none
package bkdi_pkg;

  // register indexes on the config port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BUCKETS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_CAPACITY = 1'd1;

  localparam int unsigned ACTIVE_W   = 11;
  localparam int unsigned CAP_W      = 4;
  localparam int unsigned BKT_IDX_W  = 10;
  localparam int unsigned IN_VAL_W   = 64;
  localparam int unsigned FILL_OUT_W = 4;
  localparam int unsigned IDX_RANGE  = 1024;
  // wide enough for any fill count up to 64 slots plus one
  localparam int unsigned FILL_EXT_W = 7;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic rd_issue;
    logic finish;
  } bkdi_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } bkdi_stat_t;

endpackage
`default_nettype wire

@@ rtl/bkdi_ctrl.sv @@
// Sequencer for the bucket table insert unit: reset clear, bucket read, commit.
// Depends on bkdi_pkg and the assertion macro header.
`default_nettype none
`include "bucket_table_dedup_insert_unit_assert.svh"
module bkdi_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire bkdi_pkg::bkdi_stat_t stat,
  output bkdi_pkg::bkdi_cmd_t     cmd
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // hold the read word until the result register can take the outcome
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BKDI_ASSERT_NXT(a_clear_holds, (state_r == ST_CLEAR) && !stat.clr_last, state_r == ST_CLEAR)
  `BKDI_ASSERT_NXT(a_read_then_lookup, cmd.rd_issue, state_r == ST_LOOKUP)
  `BKDI_ASSERT_IMP(a_one_command, 1'b1, $onehot0(cmd))
  `BKDI_ASSERT_NXT(a_stall_keeps_lookup, (state_r == ST_LOOKUP) && stat.out_busy, state_r == ST_LOOKUP)

endmodule
`default_nettype wire

@@ rtl/bkdi_dpath.sv @@
// Datapath: fill count and bucket memories, parallel duplicate compare, result register.
// Depends on bkdi_pkg; driven by bkdi_ctrl commands.
`default_nettype none
module bkdi_dpath #(
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned MAX_SLOTS   = 8,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire bkdi_pkg::bkdi_cmd_t              cmd,
  output bkdi_pkg::bkdi_stat_t                  stat,
  input  wire [bkdi_pkg::ACTIVE_W-1:0]          cfg_active_buckets,
  input  wire [bkdi_pkg::CAP_W-1:0]             cfg_bucket_capacity,
  input  wire [bkdi_pkg::BKT_IDX_W-1:0]         in_bucket_index,
  input  wire [bkdi_pkg::IN_VAL_W-1:0]          in_item_value,
  input  wire                                   in_skip_dup_check,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic                                  out_accepted,
  output logic [bkdi_pkg::FILL_OUT_W-1:0]       out_fill_after
);

  localparam int unsigned BKT_DEPTH =
    (MAX_BUCKETS < bkdi_pkg::IDX_RANGE) ? MAX_BUCKETS : bkdi_pkg::IDX_RANGE;
  localparam int unsigned BKT_AW = (BKT_DEPTH > 1) ? $clog2(BKT_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned EW     = bkdi_pkg::FILL_EXT_W;

  typedef logic [MAX_SLOTS-1:0][VALUE_WIDTH-1:0] bkt_word_t;

  logic [FILL_W-1:0] fill_mem [BKT_DEPTH];
  bkt_word_t         slot_mem [BKT_DEPTH];

  logic [BKT_AW-1:0]      clr_addr_r;
  logic [BKT_AW-1:0]      req_addr_r;
  logic [VALUE_WIDTH-1:0] req_val_r;
  logic                   req_force_r;
  logic                   req_ok_r;
  logic [FILL_W-1:0]      fill_rd_r;
  bkt_word_t              slot_rd_r;
  logic                   out_valid_r;
  logic                   out_accepted_r;
  logic [bkdi_pkg::FILL_OUT_W-1:0] out_fill_after_r;

  logic              bkt_in_use;
  logic [EW-1:0]     fill_x;
  logic [EW-1:0]     cap_x;
  logic [EW-1:0]     cap_eff;
  logic [EW-1:0]     fill_new_x;
  logic              hit;
  logic              ins_ok;
  logic              commit;
  bkt_word_t         slot_wd;
  logic              fill_we;
  logic [BKT_AW-1:0] fill_wa;
  logic [FILL_W-1:0] fill_wd;

  // bucket must be below both the configured count and the table size
  assign bkt_in_use =
    ({1'b0, in_bucket_index} < cfg_active_buckets) &&
    ({1'b0, in_bucket_index} < bkdi_pkg::ACTIVE_W'(BKT_DEPTH));

  assign fill_x  = EW'(fill_rd_r);
  assign cap_x   = EW'(cfg_bucket_capacity);
  assign cap_eff = (cap_x > EW'(MAX_SLOTS)) ? EW'(MAX_SLOTS) : cap_x;

  always_comb begin
    hit = 1'b0;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      if ((EW'(s) < fill_x) && (slot_rd_r[s] == req_val_r)) hit = 1'b1;
    end
  end

  assign ins_ok     = req_ok_r && (fill_x < cap_eff) && (req_force_r || !hit);
  assign fill_new_x = ins_ok ? (fill_x + EW'(1)) : fill_x;
  assign commit     = cmd.finish && ins_ok;

  always_comb begin
    for (int s = 0; s < MAX_SLOTS; s++) begin
      slot_wd[s] = (EW'(s) == fill_x) ? req_val_r : slot_rd_r[s];
    end
  end

  assign fill_we = cmd.clr_step || commit;
  assign fill_wa = cmd.clr_step ? clr_addr_r : req_addr_r;
  assign fill_wd = cmd.clr_step ? '0 : fill_new_x[FILL_W-1:0];

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    if (cmd.rd_issue) fill_rd_r <= fill_mem[in_bucket_index[BKT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (commit) slot_mem[req_addr_r] <= slot_wd;
    if (cmd.rd_issue) slot_rd_r <= slot_mem[in_bucket_index[BKT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      req_addr_r  <= in_bucket_index[BKT_AW-1:0];
      req_val_r   <= in_item_value[VALUE_WIDTH-1:0];
      req_force_r <= in_skip_dup_check;
      req_ok_r    <= bkt_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step && !stat.clr_last) begin
      clr_addr_r <= clr_addr_r + BKT_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_accepted_r   <= ins_ok;
      out_fill_after_r <= req_ok_r ? fill_new_x[bkdi_pkg::FILL_OUT_W-1:0] : '0;
    end
  end

  assign stat.clr_last = (clr_addr_r == BKT_AW'(BKT_DEPTH - 1));
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_fill_after = out_fill_after_r;

endmodule
`default_nettype wire

@@ rtl/bucket_table_dedup_insert_unit.sv @@
// Bucketed value store with duplicate rejection. Each request names a bucket, a value
// and a skip flag; it is stored in the bucket's next free slot unless the bucket is out
// of range, full, or (without the skip flag) already holds an equal value. One result
// per request: accepted flag and the bucket's fill count afterwards. A request first
// reads the whole bucket as a single memory word, then compares all slots in parallel
// and writes back; the bucket memory's read-modify-write sets this order.
// The result register lets the next request in while a result waits. After reset,
// in_ready stays low while the fill counts of all min(MAX_BUCKETS, 1024) buckets are
// cleared one bucket per cycle; config writes are taken throughout.
// Depends on bkdi_pkg, bkdi_ctrl and bkdi_dpath.
`default_nettype none
module bucket_table_dedup_insert_unit #(
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned MAX_SLOTS   = 8,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire [bkdi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [bkdi_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [bkdi_pkg::BKT_IDX_W-1:0]     in_bucket_index,
  input  wire [bkdi_pkg::IN_VAL_W-1:0]      in_item_value,
  input  wire                               in_skip_dup_check,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              out_accepted,
  output logic [bkdi_pkg::FILL_OUT_W-1:0]   out_fill_after
);

  logic [bkdi_pkg::ACTIVE_W-1:0] active_buckets_r;
  logic [bkdi_pkg::CAP_W-1:0]    bucket_capacity_r;

  bkdi_pkg::bkdi_cmd_t  cmd;
  bkdi_pkg::bkdi_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_buckets_r  <= bkdi_pkg::ACTIVE_W'(1024);
      bucket_capacity_r <= bkdi_pkg::CAP_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bkdi_pkg::CFG_ACTIVE_BUCKETS:  active_buckets_r  <= cfg_wdata;
        bkdi_pkg::CFG_BUCKET_CAPACITY: bucket_capacity_r <= cfg_wdata[bkdi_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  bkdi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bkdi_dpath #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .MAX_SLOTS   (MAX_SLOTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_active_buckets  (active_buckets_r),
    .cfg_bucket_capacity (bucket_capacity_r),
    .in_bucket_index     (in_bucket_index),
    .in_item_value       (in_item_value),
    .in_skip_dup_check   (in_skip_dup_check),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_accepted        (out_accepted),
    .out_fill_after      (out_fill_after)
  );

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for bucket_table_dedup_insert_unit: random and directed insert requests,
// results checked against an in-bench model of the bucket store. Depends on bkdi_pkg and the RTL.
`default_nettype none
module testbench;

  localparam int unsigned NUM_BUCKETS = 1024;
  localparam int unsigned NUM_SLOTS   = 8;
  localparam int unsigned VALUE_W     = 64;
  localparam int          QUIET_LIMIT = 20000;
  localparam int          LONG_HOLD   = 300;

  class bucket_insert_checker;
    typedef struct {
      bit       accepted;
      bit [3:0] fill;
    } outcome_t;

    bit [bkdi_pkg::ACTIVE_W-1:0] active_buckets;
    bit [bkdi_pkg::CAP_W-1:0]    capacity;
    int unsigned       fill_count [NUM_BUCKETS];
    bit [63:0]         slot_value [NUM_BUCKETS][NUM_SLOTS];
    outcome_t          awaited [$];
    int                errors;
    int                results_seen;

    function new();
      active_buckets = 11'd1024;
      capacity = 4'd8;
      foreach (fill_count[i]) fill_count[i] = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [bkdi_pkg::CFG_IDX_W-1:0] idx,
                            logic [bkdi_pkg::CFG_DATA_W-1:0] data);
      if (idx == bkdi_pkg::CFG_ACTIVE_BUCKETS)
        active_buckets = data[bkdi_pkg::ACTIVE_W-1:0];
      else if (idx == bkdi_pkg::CFG_BUCKET_CAPACITY)
        capacity = data[bkdi_pkg::CAP_W-1:0];
    endfunction

    // work out the outcome of one accepted request and update the store
    function void note_request(bit [bkdi_pkg::BKT_IDX_W-1:0] bkt, bit [63:0] val, bit skip);
      outcome_t    o;
      int unsigned cap;
      int unsigned fill;
      bit          ok;
      bit [63:0]   v;
      v = val & ({64{1'b1}} >> (64 - VALUE_W));
      if (bkt >= active_buckets || bkt >= NUM_BUCKETS) begin
        o.accepted = 1'b0;
        o.fill = 4'd0;
      end else begin
        cap = (capacity > NUM_SLOTS) ? NUM_SLOTS : capacity;
        fill = fill_count[bkt];
        ok = 1'b1;
        if (!skip)
          for (int i = 0; i < fill; i++)
            if (slot_value[bkt][i] == v) ok = 1'b0;
        if (fill >= cap) ok = 1'b0;
        if (ok) begin
          slot_value[bkt][fill] = v;
          fill++;
          fill_count[bkt] = fill;
        end
        o.accepted = ok;
        o.fill = fill[3:0];
      end
      awaited.insert(awaited.size(), o);
    endfunction

    function void check_result(bit accepted, bit [3:0] fill);
      outcome_t o;
      results_seen++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, accepted %0d fill %0d", $time, accepted, fill);
        errors++;
      end else begin
        o = awaited.pop_front();
        if (accepted !== o.accepted) begin
          $display("%0t: accepted mismatch, expected %0d, got %0d",
                   $time, o.accepted, accepted);
          errors++;
        end
        if (fill !== o.fill) begin
          $display("%0t: fill_after mismatch, expected %0d, got %0d", $time, o.fill, fill);
          errors++;
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [bkdi_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bkdi_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_ready;
  logic [bkdi_pkg::BKT_IDX_W-1:0]  in_bucket_index;
  logic [bkdi_pkg::IN_VAL_W-1:0]   in_item_value;
  logic                            in_skip_dup_check;
  logic                            out_valid;
  logic                            out_ready;
  logic                            out_accepted;
  logic [bkdi_pkg::FILL_OUT_W-1:0] out_fill_after;

  bucket_insert_checker sb = new();
  int quiet_cycles = 0;
  bit held_off = 1'b0;

  bucket_table_dedup_insert_unit #(
    .MAX_BUCKETS(NUM_BUCKETS),
    .MAX_SLOTS  (NUM_SLOTS),
    .VALUE_WIDTH(VALUE_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_bucket_index  (in_bucket_index),
    .in_item_value    (in_item_value),
    .in_skip_dup_check(in_skip_dup_check),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accepted     (out_accepted),
    .out_fill_after   (out_fill_after)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(input logic [bkdi_pkg::BKT_IDX_W-1:0] bkt,
                              input logic [63:0] val, input logic skip);
    in_valid <= 1'b1;
    in_bucket_index <= bkt;
    in_item_value <= val;
    in_skip_dup_check <= skip;
    do @(posedge clk); while (!in_ready);
    sb.note_request(bkt, val, skip);
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [bkdi_pkg::ACTIVE_W-1:0] act,
                            input logic [bkdi_pkg::CAP_W-1:0] cap);
    cfg_we <= 1'b1;
    cfg_index <= bkdi_pkg::CFG_ACTIVE_BUCKETS;
    cfg_wdata <= act;
    @(posedge clk);
    sb.write_reg(bkdi_pkg::CFG_ACTIVE_BUCKETS, act);
    cfg_index <= bkdi_pkg::CFG_BUCKET_CAPACITY;
    cfg_wdata <= bkdi_pkg::CFG_DATA_W'(cap);
    @(posedge clk);
    sb.write_reg(bkdi_pkg::CFG_BUCKET_CAPACITY, bkdi_pkg::CFG_DATA_W'(cap));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    send_request(10'd0, 64'd0, 1'b0);
    send_request(10'd0, 64'd0, 1'b0);   // duplicate
    send_request(10'd0, 64'd0, 1'b1);   // duplicate forced in
    send_request(10'd1023, {64{1'b1}}, 1'b0);
    send_request(10'd1023, {64{1'b1}}, 1'b0);
    send_request(10'd1023, {64{1'b1}}, 1'b1);
    for (int i = 0; i < 8; i++)
      send_request(10'd5, 64'h8000_0000_0000_0000 >> i, 1'b0);
    send_request(10'd5, 64'h0123_4567_89ab_cdef, 1'b0);   // full
    send_request(10'd5, 64'h0123_4567_89ab_cdef, 1'b1);
    drain();
    // one bucket, capacity below the current fill
    set_config(11'd1, 4'd1);
    send_request(10'd0, 64'h55, 1'b1);
    send_request(10'd1, 64'h55, 1'b0);
    send_request(10'd1023, 64'h55, 1'b0);
    drain();
    set_config(11'd0, 4'd8);
    send_request(10'd0, 64'h77, 1'b1);
    drain();
    // count beyond the bucket range, capacity beyond the slot count
    set_config(11'd2047, 4'd15);
    send_request(10'd2, 64'ha5a5_a5a5_5a5a_5a5a, 1'b0);
    send_request(10'd2, 64'ha5a5_a5a5_5a5a_5a5a, 1'b0);
    drain();
    set_config(11'd2047, 4'd0);
    send_request(10'd2, 64'h1, 1'b0);
    send_request(10'd7, 64'h1, 1'b1);
    drain();
  endtask

  task automatic run_phase(input int n_items, input logic [bkdi_pkg::ACTIVE_W-1:0] act,
                           input logic [bkdi_pkg::CAP_W-1:0] cap);
    logic [63:0]                    pool [6];
    logic [bkdi_pkg::BKT_IDX_W-1:0] bkt;
    logic [63:0]                    val;
    int unsigned                    lim;
    int unsigned                    hot_base;
    int                             left;
    int                             burst;
    int                             gap;
    int                             r;
    set_config(act, cap);
    lim = (act > NUM_BUCKETS) ? NUM_BUCKETS : act;
    hot_base = $urandom_range(0, (lim > 16) ? lim - 16 : 0);
    foreach (pool[i]) pool[i] = rand64();
    case ($urandom_range(0, 2))
      0: pool[0] = 64'd0;
      1: pool[0] = {64{1'b1}};
      default: ;
    endcase
    left = n_items;
    while (left > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
      for (int j = 0; j < burst && left > 0; j++) begin
        r = $urandom_range(0, 99);
        if (r < 80)
          bkt = bkdi_pkg::BKT_IDX_W'(hot_base + $urandom_range(0, 15));
        else if (r < 90)
          bkt = bkdi_pkg::BKT_IDX_W'($urandom_range(0, NUM_BUCKETS - 1));
        else  // around the active limit
          bkt = bkdi_pkg::BKT_IDX_W'(int'(act) - 1 + $urandom_range(0, 2));
        val = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 5)] : rand64();
        send_request(bkt, val, $urandom_range(0, 99) < 15);
        left--;
      end
      gap = $urandom_range(0, 8);
      if (left > 0 && gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    drain();
  endtask

  // receiver: segments of steady, random and sparse ready, plus one long hold-off
  initial begin
    int seg_len;
    int mode;
    out_ready <= 1'b0;
    forever begin
      if (!held_off && sb.results_seen >= 400 && in_valid) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held_off = 1'b1;
      end
      seg_len = $urandom_range(8, 64);
      mode = $urandom_range(0, 2);
      for (int k = 0; k < seg_len; k++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_accepted, out_fill_after);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= bkdi_pkg::CFG_ACTIVE_BUCKETS;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_bucket_index <= '0;
    in_item_value <= '0;
    in_skip_dup_check <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_phase(150, 11'd1024, 4'd8);
    run_phase(130, 11'd512, 4'd4);
    run_phase(60, 11'd1, 4'd8);
    run_phase(150, 11'd2047, 4'd15);
    run_phase(30, 11'd0, 4'd3);
    run_phase(110, 11'd300, 4'd1);
    run_phase(60, 11'd1024, 4'd0);
    run_phase(150, bkdi_pkg::ACTIVE_W'($urandom_range(1, 1024)),
              bkdi_pkg::CAP_W'($urandom_range(1, 8)));
    run_phase(200, 11'd1024, 4'd8);
    run_phase(100, 11'd17, 4'd2);
    run_phase(110, bkdi_pkg::ACTIVE_W'($urandom_range(1, 1024)),
              bkdi_pkg::CAP_W'($urandom_range(1, 8)));
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
